FILE: hdl/cictt_pkg.sv
// Shared types and constants for the CAN ID cycle-time table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package cictt_pkg;

  localparam int CICTT_TS_W   = 64;
  localparam int CICTT_ID_W   = 29;
  localparam int CICTT_DLC_W  = 4;
  localparam int CICTT_PAY_W  = 64;
  localparam int CICTT_SEL_W  = 6;
  localparam int CICTT_ROW_W  = 6;
  localparam int CICTT_USED_W = 7;
  localparam int CICTT_AVG_W  = 32;
  localparam int CICTT_IN_W   = 168;
  localparam int CICTT_OUT_W  = 208;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } cictt_action_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_READ_MT  = 3'd4,
    ST_CLEARED  = 3'd5
  } cictt_status_e;

  // controller -> datapath
  typedef struct packed {
    logic          latch_in;
    logic          occ_clear;
    logic          occ_inc;
    logic          row_clear;
    logic          row_inc;
    logic          row_from_sel;
    logic          row_from_occ;
    logic          ent_wr_hit;
    logic          ent_wr_new;
    logic          ring_wr_hit;
    logic          ring_wr_zero;
    logic          slot_clear;
    logic          slot_inc;
    logic          sum_clear;
    logic          sum_acc;
    logic          div_start;
    logic          div_step;
    logic          out_load;
    logic          out_blank;
    logic          blank_sel;
    cictt_status_e status;
  } cictt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cictt_action_e action;
    logic          occ_zero;
    logic          occ_full;
    logic          sel_hit;
    logic          id_match;
    logic          row_last;
    logic          slot_last;
    logic          slot_end;
    logic          out_busy;
  } cictt_sts_t;

endpackage
`default_nettype wire

FILE: hdl/cictt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cictt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/cictt_dp.sv
// Datapath: input beat register, row table RAM, interval ring RAM, sum and
// reciprocal divide, output register. Depends on cictt_pkg and cictt_ram.
`timescale 1ns / 1ps
`default_nettype none
module cictt_dp #(
  parameter int TABLE_ROWS = 64,
  parameter int RING_SLOTS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [cictt_pkg::CICTT_IN_W-1:0]   s_tdata_i,
  input  wire logic [1:0]                         s_tuser_i,
  input  wire cictt_pkg::cictt_cmd_t              cmd_i,
  output cictt_pkg::cictt_sts_t                   sts_o,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  output logic [cictt_pkg::CICTT_OUT_W-1:0]       m_tdata_o,
  output logic [2:0]                              m_tuser_o
);
  import cictt_pkg::*;

  localparam int RW  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int OW  = $clog2(TABLE_ROWS + 1);
  localparam int PW  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SW  = $clog2(RING_SLOTS + 1);
  localparam int RD  = TABLE_ROWS * RING_SLOTS;
  localparam int AW  = (RD > 1) ? $clog2(RD) : 1;
  // q = (n * REC) >> QSH is exact for every 32-bit n
  localparam int QSH = 32 + $clog2(RING_SLOTS);
  localparam logic [32:0] REC =
    33'(((64'd1 << QSH) + 64'(RING_SLOTS) - 64'd1) / 64'(RING_SLOTS));
  localparam int EW  = CICTT_ID_W + CICTT_DLC_W + CICTT_PAY_W + CICTT_TS_W + PW;
  localparam int O_DLC = CICTT_ID_W;
  localparam int O_PAY = O_DLC + CICTT_DLC_W;
  localparam int O_TS  = O_PAY + CICTT_PAY_W;
  localparam int O_POS = O_TS + CICTT_TS_W;

  // latched input beat
  cictt_action_e          act_q;
  logic [CICTT_TS_W-1:0]  ts_q;
  logic [CICTT_ID_W-1:0]  id_q;
  logic [CICTT_DLC_W-1:0] dlc_q;
  logic [CICTT_PAY_W-1:0] pay_q;
  logic [CICTT_SEL_W-1:0] sel_q;

  logic [OW-1:0] occ_q;
  logic [RW-1:0] row_q;
  logic [SW-1:0] slot_q;
  logic          out_valid_q;
  logic [31:0]   sum_q;
  logic [31:0]   dq_q;
  logic          neg_q;
  logic [CICTT_OUT_W-1:0] out_data_q;
  logic [2:0]    out_user_q;

  logic [EW-1:0]  ent_rdata;
  logic [EW-1:0]  ent_wdata;
  logic [31:0]    ring_rdata;
  logic [31:0]    ring_wdata;
  logic [AW-1:0]  ring_base;
  logic [AW-1:0]  ring_waddr;
  logic [AW-1:0]  ring_raddr;
  logic [PW:0]    pos_inc;
  logic [PW-1:0]  pos_new;
  logic [64:0]    prod;
  logic [31:0]    avg;

  logic [CICTT_ID_W-1:0]  e_id;
  logic [CICTT_DLC_W-1:0] e_dlc;
  logic [CICTT_PAY_W-1:0] e_pay;
  logic [CICTT_TS_W-1:0]  e_last;
  logic [PW-1:0]          e_pos;

  assign e_id   = ent_rdata[CICTT_ID_W-1:0];
  assign e_dlc  = ent_rdata[O_PAY-1:O_DLC];
  assign e_pay  = ent_rdata[O_TS-1:O_PAY];
  assign e_last = ent_rdata[O_POS-1:O_TS];
  assign e_pos  = ent_rdata[EW-1:O_POS];

  assign pos_inc = {1'b0, e_pos} + (PW+1)'(1);
  assign pos_new = (pos_inc >= (PW+1)'(RING_SLOTS)) ? '0 : pos_inc[PW-1:0];

  assign ent_wdata = {(cmd_i.ent_wr_hit ? pos_new : PW'(0)), ts_q, pay_q, dlc_q, id_q};

  assign ring_base  = AW'(row_q) * AW'(RING_SLOTS);
  assign ring_waddr = ring_base + (cmd_i.ring_wr_hit ? AW'(pos_new) : AW'(slot_q));
  assign ring_raddr = ring_base + AW'(slot_q);
  assign ring_wdata = cmd_i.ring_wr_hit ? (ts_q[31:0] - e_last[31:0]) : 32'd0;

  cictt_ram #(.WIDTH(EW), .DEPTH(TABLE_ROWS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ent_wr_hit | cmd_i.ent_wr_new),
    .waddr_i (row_q),
    .wdata_i (ent_wdata),
    .raddr_i (row_q),
    .rdata_o (ent_rdata)
  );

  cictt_ram #(.WIDTH(32), .DEPTH(RD)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring_wr_hit | cmd_i.ring_wr_zero),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign prod = 65'(dq_q) * 65'(REC);
  assign avg  = neg_q ? (32'd0 - dq_q) : dq_q;

  always_comb begin
    sts_o.action    = act_q;
    sts_o.occ_zero  = (occ_q == '0);
    sts_o.occ_full  = (occ_q >= OW'(TABLE_ROWS));
    sts_o.sel_hit   = (16'(sel_q) < 16'(occ_q));
    sts_o.id_match  = (e_id == id_q);
    sts_o.row_last  = ((OW'(row_q) + OW'(1)) == occ_q);
    sts_o.slot_last = (slot_q == SW'(RING_SLOTS - 1));
    sts_o.slot_end  = (slot_q == SW'(RING_SLOTS));
    sts_o.out_busy  = out_valid_q & ~m_tready_i;
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      row_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.occ_clear) begin
        occ_q <= '0;
      end else if (cmd_i.occ_inc) begin
        occ_q <= occ_q + OW'(1);
      end
      if (cmd_i.row_clear) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + RW'(1);
      end else if (cmd_i.row_from_sel) begin
        row_q <= RW'(sel_q);
      end else if (cmd_i.row_from_occ) begin
        row_q <= RW'(occ_q);
      end
      if (cmd_i.slot_clear) begin
        slot_q <= '0;
      end else if (cmd_i.slot_inc) begin
        slot_q <= slot_q + SW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= cictt_action_e'(s_tuser_i);
      ts_q  <= s_tdata_i[63:0];
      id_q  <= s_tdata_i[92:64];
      dlc_q <= s_tdata_i[96:93];
      pay_q <= s_tdata_i[160:97];
      sel_q <= s_tdata_i[166:161];
    end
    if (cmd_i.sum_clear) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc && (slot_q != '0)) begin
      sum_q <= sum_q + ring_rdata;
    end
    if (cmd_i.div_start) begin
      neg_q <= sum_q[31];
      dq_q  <= sum_q[31] ? (32'd0 - sum_q) : sum_q;
    end else if (cmd_i.div_step) begin
      dq_q  <= 32'(prod >> QSH);
    end
    if (cmd_i.out_load) begin
      out_user_q <= cmd_i.status;
      if (cmd_i.out_blank) begin
        out_data_q <= {{(CICTT_OUT_W-13){1'b0}}, CICTT_USED_W'(occ_q),
                       (cmd_i.blank_sel ? sel_q : 6'd0)};
      end else begin
        out_data_q <= {2'b00, e_last, avg, e_pay, e_dlc, e_id,
                       CICTT_USED_W'(occ_q), CICTT_ROW_W'(row_q)};
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule
`default_nettype wire

FILE: hdl/cictt_ctrl.sv
// Controller state machine: sequences lookup, update, insert or drop, read, clear,
// ring sum and divide. Depends on cictt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cictt_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire cictt_pkg::cictt_sts_t sts_i,
  output cictt_pkg::cictt_cmd_t      cmd_o
);
  import cictt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CMP, S_HIT, S_MISS, S_NEW_WR,
    S_ZERO, S_ENT_RD, S_SUM, S_DIV_LOAD, S_DIV, S_DONE
  } state_e;

  state_e        state_q, state_d;
  cictt_status_e status_q, status_d;
  logic          blank_q, blank_d;
  logic          bsel_q, bsel_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    blank_d  = blank_q;
    bsel_d   = bsel_q;
    cmd_o           = '0;
    cmd_o.status    = status_q;
    cmd_o.out_blank = blank_q;
    cmd_o.blank_sel = bsel_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.action)
          ACT_FRAME: begin
            cmd_o.row_clear = 1'b1;
            state_d = sts_i.occ_zero ? S_MISS : S_SCAN_RD;
          end
          ACT_READ: begin
            if (sts_i.sel_hit) begin
              cmd_o.row_from_sel = 1'b1;
              status_d = ST_READ_OK;
              blank_d  = 1'b0;
              state_d  = S_ENT_RD;
            end else begin
              status_d = ST_READ_MT;
              blank_d  = 1'b1;
              bsel_d   = 1'b1;
              state_d  = S_DONE;
            end
          end
          ACT_CLEAR: begin
            cmd_o.occ_clear = 1'b1;
            status_d = ST_CLEARED;
            blank_d  = 1'b1;
            bsel_d   = 1'b0;
            state_d  = S_DONE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.id_match) begin
          state_d = S_HIT;
        end else if (sts_i.row_last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_HIT: begin
        cmd_o.ent_wr_hit  = 1'b1;
        cmd_o.ring_wr_hit = 1'b1;
        status_d = ST_UPDATED;
        blank_d  = 1'b0;
        state_d  = S_ENT_RD;
      end
      S_MISS: begin
        if (sts_i.occ_full) begin
          status_d = ST_DROPPED;
          blank_d  = 1'b1;
          bsel_d   = 1'b0;
          state_d  = S_DONE;
        end else begin
          cmd_o.row_from_occ = 1'b1;
          cmd_o.occ_inc      = 1'b1;
          state_d = S_NEW_WR;
        end
      end
      S_NEW_WR: begin
        cmd_o.ent_wr_new = 1'b1;
        cmd_o.slot_clear = 1'b1;
        status_d = ST_INSERTED;
        blank_d  = 1'b0;
        state_d  = S_ZERO;
      end
      S_ZERO: begin
        cmd_o.ring_wr_zero = 1'b1;
        cmd_o.slot_inc     = 1'b1;
        if (sts_i.slot_last) begin
          state_d = S_ENT_RD;
        end
      end
      S_ENT_RD: begin
        cmd_o.slot_clear = 1'b1;
        cmd_o.sum_clear  = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.slot_inc = 1'b1;
        cmd_o.sum_acc  = 1'b1;
        if (sts_i.slot_end) begin
          state_d = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_UPDATED;
      blank_q  <= 1'b0;
      bsel_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      blank_q  <= blank_d;
      bsel_q   <= bsel_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/can_id_cycle_time_table_unit.sv
// One beat in flight; the next is accepted once the controller is back in idle
// after loading the output register. The linear ID scan (a read and a compare
// state per row), the ring zero pass and the ring sum set the work per beat;
// the average is a single reciprocal multiply.
// Reset: async, active low; table empty after reset, no clearing pass. Uses cictt_*.
`timescale 1ns / 1ps
`default_nettype none
module can_id_cycle_time_table_unit #(
  parameter int TABLE_ROWS = 64,
  parameter int RING_SLOTS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [63:0] timestamp, [92:64] frame_id, [96:93] frame_dlc,
  // [160:97] frame_payload, [166:161] row_select, [167] zero
  input  wire logic [cictt_pkg::CICTT_IN_W-1:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [5:0] row_number, [12:6] rows_used, [41:13] row_id, [45:42] row_dlc,
  // [109:46] row_payload, [141:110] average_cycle, [205:142] last_seen, [207:206] zero
  output logic [cictt_pkg::CICTT_OUT_W-1:0]     m_axis_tdata,
  // [2:0] status
  output logic [2:0]                            m_axis_tuser
);
  import cictt_pkg::*;

  cictt_cmd_t cmd;
  cictt_sts_t sts;

  // Controller: one beat at a time, sequencing scan / update / sum / divide.
  cictt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: table and ring RAMs, ring sum, divider, output register that
  // lets the next beat in while a result waits downstream.
  cictt_dp #(
    .TABLE_ROWS (TABLE_ROWS),
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[12:6]) <= TABLE_ROWS))
    else $error("rows_used above table size");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_CLEARED)) |-> (m_axis_tdata[12:6] == 7'd0))
    else $error("clear result with rows in use");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_DROPPED)) |->
      (32'(m_axis_tdata[12:6]) == TABLE_ROWS))
    else $error("frame dropped with free rows");
`endif

endmodule
`default_nettype wire

FILE: sim/can_id_cycle_time_table_unit_tb.sv
// Self-checking bench for the CAN ID cycle-time table: drives frame, read, clear and
// unused-action beats, predicts each result in a scoreboard and compares field by field.
// Depends on cictt_pkg and can_id_cycle_time_table_unit.
`timescale 1ns / 1ps
`default_nettype none
module can_id_cycle_time_table_unit_tb;
  import cictt_pkg::*;

  localparam int ROWS  = 64;
  localparam int SLOTS = 8;

  typedef struct packed {
    cictt_status_e status;
    logic [5:0]    row_number;
    logic [6:0]    rows_used;
    logic [28:0]   row_id;
    logic [3:0]    row_dlc;
    logic [63:0]   row_payload;
    logic [31:0]   average_cycle;
    logic [63:0]   last_seen;
  } table_result_t;

  // Mirror of the ID table; computes the result, if any, each accepted beat should give.
  class id_table_scoreboard;
    logic [28:0]   ids     [ROWS];
    logic [3:0]    dlcs    [ROWS];
    logic [63:0]   payloads[ROWS];
    logic [63:0]   lasts   [ROWS];
    logic [31:0]   ring    [ROWS][SLOTS];
    int            pos     [ROWS];
    int            used;
    int            errors;
    int            results_seen;
    table_result_t awaited[$];

    function int pending();
      return awaited.size();
    endfunction

    function logic [31:0] ring_average(int r);
      logic [31:0] sum;
      sum = '0;
      for (int s = 0; s < SLOTS; s++) sum += ring[r][s];
      return $signed(sum) / SLOTS;
    endfunction

    function table_result_t row_view(cictt_status_e st, int r);
      table_result_t t;
      t.status = st;
      t.row_number = r[5:0];
      t.rows_used = used[6:0];
      t.row_id = ids[r];
      t.row_dlc = dlcs[r];
      t.row_payload = payloads[r];
      t.average_cycle = ring_average(r);
      t.last_seen = lasts[r];
      return t;
    endfunction

    function table_result_t blank_view(cictt_status_e st, int r);
      table_result_t t;
      t = '0;
      t.status = st;
      t.row_number = r[5:0];
      t.rows_used = used[6:0];
      return t;
    endfunction

    function void note_beat(cictt_action_e act, logic [63:0] ts, logic [28:0] id,
                            logic [3:0] dlc, logic [63:0] pay, logic [5:0] sel);
      int hit;
      hit = -1;
      case (act)
        ACT_FRAME: begin
          for (int r = 0; r < used; r++)
            if (hit < 0 && ids[r] == id) hit = r;
          if (hit >= 0) begin
            pos[hit] = (pos[hit] + 1) % SLOTS;
            dlcs[hit] = dlc;
            payloads[hit] = pay;
            ring[hit][pos[hit]] = 32'(ts - lasts[hit]);
            lasts[hit] = ts;
            awaited.push_back(row_view(ST_UPDATED, hit));
          end else if (used >= ROWS) begin
            awaited.push_back(blank_view(ST_DROPPED, 0));
          end else begin
            ids[used] = id;
            dlcs[used] = dlc;
            payloads[used] = pay;
            lasts[used] = ts;
            for (int s = 0; s < SLOTS; s++) ring[used][s] = '0;
            pos[used] = 0;
            used++;
            awaited.push_back(row_view(ST_INSERTED, used - 1));
          end
        end
        ACT_READ: begin
          if (sel < used) awaited.push_back(row_view(ST_READ_OK, sel));
          else awaited.push_back(blank_view(ST_READ_MT, sel));
        end
        ACT_CLEAR: begin
          used = 0;
          awaited.push_back(blank_view(ST_CLEARED, 0));
        end
        default: ;  // unused action: no result
      endcase
    endfunction

    function void check_beat(logic [2:0] user, logic [CICTT_OUT_W-1:0] data);
      table_result_t e, a;
      a.status = cictt_status_e'(user);
      a.row_number = data[5:0];
      a.rows_used = data[12:6];
      a.row_id = data[41:13];
      a.row_dlc = data[45:42];
      a.row_payload = data[109:46];
      a.average_cycle = data[141:110];
      a.last_seen = data[205:142];
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, a);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (a.status != e.status)
        $display("%0t: status exp %0d act %0d", $time, e.status, a.status);
      if (a.row_number != e.row_number)
        $display("%0t: row_number exp %0d act %0d", $time, e.row_number, a.row_number);
      if (a.rows_used != e.rows_used)
        $display("%0t: rows_used exp %0d act %0d", $time, e.rows_used, a.rows_used);
      if (a.row_id != e.row_id)
        $display("%0t: row_id exp %h act %h", $time, e.row_id, a.row_id);
      if (a.row_dlc != e.row_dlc)
        $display("%0t: row_dlc exp %h act %h", $time, e.row_dlc, a.row_dlc);
      if (a.row_payload != e.row_payload)
        $display("%0t: row_payload exp %h act %h", $time, e.row_payload, a.row_payload);
      if (a.average_cycle != e.average_cycle)
        $display("%0t: average_cycle exp %0d act %0d", $time,
                 $signed(e.average_cycle), $signed(a.average_cycle));
      if (a.last_seen != e.last_seen)
        $display("%0t: last_seen exp %h act %h", $time, e.last_seen, a.last_seen);
      if (a != e) errors++;
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CICTT_IN_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = ACT_FRAME;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [CICTT_OUT_W-1:0] m_axis_tdata;
  logic [2:0]             m_axis_tuser;

  id_table_scoreboard sb = new();
  bit quiet = 0;        // no idling on either side
  bit hold_req = 0;     // ask the receiver for one long hold-off
  logic [63:0] clock_now = 64'd1000;
  logic [28:0] id_pool[72];
  int beats_sent = 0;

  always #10 clk_i = ~clk_i;

  can_id_cycle_time_table_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Result side: check accepted beats, stall at random, one long hold-off.
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static bit hold_done = 0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tuser, m_axis_tdata);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  // Offer one beat and return once it has been accepted. Valid stays high
  // across back-to-back beats; idles drop it for a random count of cycles.
  task automatic send_beat(cictt_action_e act, logic [63:0] ts, logic [28:0] id,
                           logic [3:0] dlc, logic [63:0] pay, logic [5:0] sel);
    if (!quiet && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {1'b0, sel, pay, dlc, id, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(act, ts, id, dlc, pay, sel);
    beats_sent++;
  endtask

  task automatic send_frame(logic [63:0] ts, logic [28:0] id);
    send_beat(ACT_FRAME, ts, id, 4'($urandom), {$urandom, $urandom}, 6'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    logic [63:0] ts;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty reads, extremes, hit updates with wrapping intervals.
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd0);
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd63);
    send_beat(ACT_FRAME, 64'd0, 29'd0, 4'd0, 64'd0, 6'd0);
    send_beat(ACT_FRAME, '1, '1, 4'hf, '1, 6'h3f);
    send_beat(ACT_FRAME, 64'd100, 29'd0, 4'd8, 64'h0123_4567_89ab_cdef, 6'd0);
    send_beat(ACT_FRAME, 64'd50, 29'd0, 4'd3, 64'h55aa, 6'd0);        // negative interval
    send_beat(ACT_FRAME, 64'h1_0000_0050, 29'd0, 4'd1, 64'd7, 6'd0);  // gap past 32 bits
    send_beat(ACT_FRAME, 64'h0, '1, 4'd2, 64'd9, 6'd0);               // huge wrap
    for (int i = 0; i < 9; i++)                                          // ring wraps
      send_beat(ACT_FRAME, 64'h1_0000_0050 + 64'(i + 1) * 64'h7fff_ffff, 29'd0,
                4'd4, 64'd1, 6'd0);
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd0);
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd1);
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd2);
    send_beat(ACT_NONE, '1, '1, '1, '1, '1);
    send_beat(ACT_CLEAR, '1, '1, '1, '1, '1);
    send_beat(ACT_READ, '0, '0, '0, '0, 6'd0);

    // Random: a 72-entry ID pool overfills the 64-row table, so drops happen.
    foreach (id_pool[i]) id_pool[i] = 29'($urandom);
    for (int n = 0; n < 1100; n++) begin
      if (n == 300) hold_req = 1;
      if (n == 600) wait_drained();
      quiet = (n >= 700 && n < 850);
      pick = $urandom_range(999);
      if ($urandom_range(9) == 0) ts = {$urandom, $urandom};
      else begin
        clock_now += $urandom_range(0, 20000);
        ts = clock_now;
      end
      if (pick < 600) send_frame(ts, id_pool[$urandom_range(71)]);
      else if (pick < 680) send_frame(ts, 29'($urandom));
      else if (pick < 970) send_beat(ACT_READ, '0, '0, '0, '0, 6'($urandom));
      else if (pick < 975) send_beat(ACT_CLEAR, ts, 29'($urandom), 4'($urandom),
                                     {$urandom, $urandom}, 6'($urandom));
      else send_beat(ACT_NONE, ts, 29'($urandom), 4'($urandom),
                     {$urandom, $urandom}, 6'($urandom));
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("%0d beats sent, %0d results checked (frames, reads, clears, drops).",
             beats_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("can_id_cycle_time_table_unit_tb: done, clean");
    else
      $display("can_id_cycle_time_table_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout, %0d results still awaited", sb.pending());
    $display("can_id_cycle_time_table_unit_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: can_id_cycle_time_table_unit.f
hdl/cictt_pkg.sv
hdl/cictt_ram.sv
hdl/cictt_dp.sv
hdl/cictt_ctrl.sv
hdl/can_id_cycle_time_table_unit.sv
sim/can_id_cycle_time_table_unit_tb.sv
